// ===== src/epi_pkg.sv =====
// Shared types, constants and a helper function for the essential implicant selector.
package epi_pkg;

   // Width of one chart row and of the result masks.
   localparam int unsigned ROW_W = 32;
   // Width of the implicant count field.
   localparam int unsigned CNT_W = 6;
   // Largest number of implicant columns the chart supports.
   localparam int unsigned MAX_COLS = 32;

   // Sequencer states, one-hot coded.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ESS  = 4'b0010,
      ST_COM  = 4'b0100,
      ST_DONE = 4'b1000
   } epi_state_type;

   // Control from the sequencer to the scan unit.
   typedef struct packed {
      logic ess_clear;  // start a new essential set
      logic ess_en;     // fold the current row into the essential set
      logic com_load;   // seed the common cover with the used columns outside the essential set
      logic com_en;     // fold the current row into the common cover
   } epi_scan_ctrl_type;

   // Mask of the columns in use; counts of MAX_COLS or more give a full mask.
   function automatic logic [ROW_W-1:0] col_mask(input logic [CNT_W-1:0] n);
      logic [ROW_W-1:0] m;
      if (n >= CNT_W'(MAX_COLS)) begin
         m = {ROW_W{1'b1}};
      end else begin
         m = ~({ROW_W{1'b1}} << n[4:0]);
      end
      return m;
   endfunction

endpackage

// ===== src/epi_row_mem.sv =====
// Chart row storage: one write port and one registered read port.
module epi_row_mem #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned AW    = 8
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [epi_pkg::ROW_W-1:0] wr_data,
   input  logic [AW-1:0]             rd_addr,
   output logic [epi_pkg::ROW_W-1:0] rd_data
);
   import epi_pkg::*;

   logic [ROW_W-1:0] mem_ff [DEPTH];
   logic [ROW_W-1:0] rd_data_ff;

   // Row write during loading.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read used by both passes.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/epi_scan_unit.sv =====
// Shared row evaluation unit: sole-cover detection and common-cover accumulation.
module epi_scan_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  epi_pkg::epi_scan_ctrl_type ctrl,
   input  logic [epi_pkg::ROW_W-1:0] row_data,
   input  logic [epi_pkg::ROW_W-1:0] col_mask_val,
   output logic [epi_pkg::ROW_W-1:0] essential_mask,
   output logic [epi_pkg::ROW_W-1:0] selected_mask
);
   import epi_pkg::*;

   logic [ROW_W-1:0] ess_ff, ess_in;
   logic [ROW_W-1:0] com_ff, com_in;
   logic             any_ff, any_in;
   logic [ROW_W-1:0] row_used;
   logic             single;
   logic             uncovered;

   // The row limited to the columns in use, and its two tests.
   always_comb begin
      row_used  = row_data & col_mask_val;
      single    = (row_used != '0) && ((row_used & (row_used - ROW_W'(1))) == '0);
      uncovered = ((row_used & ess_ff) == '0);
   end

   // Next values of the accumulators.
   always_comb begin
      ess_in = ess_ff;
      com_in = com_ff;
      any_in = any_ff;
      if (ctrl.ess_clear) begin
         ess_in = '0;
      end else if (ctrl.ess_en && single) begin
         ess_in = ess_ff | row_used;
      end
      if (ctrl.com_load) begin
         com_in = col_mask_val & ~ess_ff;
         any_in = 1'b0;
      end else if (ctrl.com_en && uncovered) begin
         com_in = com_ff & row_used;
         any_in = 1'b1;
      end
   end

   // The essential set is state that reset clears; the cover is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         ess_ff <= '0;
         any_ff <= 1'b0;
      end else begin
         ess_ff <= ess_in;
         any_ff <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      com_ff <= com_in;
   end

   // With no uncovered rows the common cover is not used and only the essential set is selected.
   assign essential_mask = ess_ff;
   assign selected_mask  = any_ff ? (ess_ff | com_ff) : ess_ff;

endmodule

// ===== src/essential_prime_implicant_select.sv =====
// Top level: row loading, two-pass sequencer and result strobe.
//
// Rows of a prime implicant chart are loaded one per cycle (start high while
// busy is low); each row is written into an internal memory of MAX_ROWS
// entries, and rows beyond that are dropped. The row marked last closes the
// chart: busy then stays high while the single memory read port walks all
// stored rows twice, once to find the essential columns and once to AND the
// rows they leave uncovered. The result appears on the rsp_ ports for exactly
// one cycle with rsp_strobe high and must be captured then, since the receiver
// cannot stall the block. The column count used is that of the last row.
module essential_prime_implicant_select #(
   parameter int unsigned MAX_ROWS = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [epi_pkg::ROW_W-1:0] req_coverage_row,
   input  logic [epi_pkg::CNT_W-1:0] req_implicant_count,
   input  logic                      req_last_row,
   output logic                      rsp_strobe,
   output logic [epi_pkg::ROW_W-1:0] rsp_selected_mask,
   output logic [epi_pkg::ROW_W-1:0] rsp_essential_mask
);
   import epi_pkg::*;

   localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int unsigned CW = $clog2(MAX_ROWS + 1);

   epi_state_type     state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              vld_ff, vld_in;
   logic [ROW_W-1:0]  cm_ff, cm_in;
   logic              accept;
   logic              store;
   logic              issue;
   logic [ROW_W-1:0]  rd_data;
   epi_scan_ctrl_type ctrl;

   assign accept = start && !busy;
   assign store  = accept && (count_ff < CW'(MAX_ROWS));
   assign issue  = (idx_ff != count_ff);

   // Sequencer: load rows, then the essential pass, the cover pass and the result.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      vld_in   = 1'b0;
      cm_in    = cm_ff;
      ctrl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cm_in = col_mask(req_implicant_count);
               if (store) begin
                  count_in = count_ff + CW'(1);
               end
               if (req_last_row) begin
                  state_in       = ST_ESS;
                  idx_in         = '0;
                  ctrl.ess_clear = 1'b1;
               end
            end
         end
         ST_ESS: begin
            ctrl.ess_en = vld_ff;
            if (issue) begin
               idx_in = idx_ff + CW'(1);
               vld_in = 1'b1;
            end else if (!vld_ff) begin
               state_in      = ST_COM;
               idx_in        = '0;
               ctrl.com_load = 1'b1;
            end
         end
         ST_COM: begin
            ctrl.com_en = vld_ff;
            if (issue) begin
               idx_in = idx_ff + CW'(1);
               vld_in = 1'b1;
            end else if (!vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
            count_in = '0;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         vld_ff   <= 1'b0;
         cm_ff    <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         vld_ff   <= vld_in;
         cm_ff    <= cm_in;
      end
   end

   // Row memory: written while loading, read by both passes.
   epi_row_mem #(
      .DEPTH(MAX_ROWS),
      .AW   (AW)
   ) u_row_mem (
      .clock  (clock),
      .wr_en  (store),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(req_coverage_row),
      .rd_addr(idx_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   // Shared row evaluation.
   epi_scan_unit u_scan (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .row_data      (rd_data),
      .col_mask_val  (cm_ff),
      .essential_mask(rsp_essential_mask),
      .selected_mask (rsp_selected_mask)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_DONE);

endmodule
